/* rtl/core/clbs_pkg.sv */
// Shared types and constants for the conveyor lift ball sequencer.
package clbs_pkg;

  // Drive levels are signed Q1.15
  localparam int unsigned LevelW = 16;
  // Tick-age counters and lockout length
  localparam int unsigned AgeW   = 16;
  localparam int unsigned CountW = 2;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] MaxBalls   = 2'd3;
  localparam logic [CountW-1:0] ResetBalls = 2'd2;
  localparam logic [AgeW-1:0]   AgeMax     = {AgeW{1'b1}};

  typedef logic signed [LevelW-1:0] level_t;
  typedef logic [AgeW-1:0]          age_t;
  typedef logic [CountW-1:0]        count_t;
  typedef logic [CodeW-1:0]         code_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgIntakeHold   = 3'd0,
    CfgLiftSpeed    = 3'd1,
    CfgRevLiftSpeed = 3'd2,
    CfgRevIntSpeed  = 3'd3,
    CfgIntakeSpeed  = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam age_t   HoldReset     = 16'd50;
  localparam level_t FwdSpeedReset = 16'sh7FFF;
  localparam level_t RevSpeedReset = 16'sh8000;

  // Saturating increment of a tick age
  function automatic age_t age_inc(input age_t a);
    age_t r;
    r = (a == AgeMax) ? AgeMax : a + age_t'(1);
    return r;
  endfunction

endpackage

/* rtl/core/clbs_if.sv */
// Channel interfaces: control tick in, drive result out.
interface clbs_in_if;
  logic                  valid;
  logic                  ready;
  logic                  top_raw;
  logic                  top_debounced;
  logic                  mid_raw;
  logic                  mid_debounced;
  logic                  bot_raw;
  logic                  fire_request;
  logic [15:0]           fire_lockout;
  logic                  reverse_request;
  logic                  queue_request;
  logic                  intake_cmd_valid;
  logic                  intake_on;

  modport source (
    output valid, top_raw, top_debounced, mid_raw, mid_debounced, bot_raw,
           fire_request, fire_lockout, reverse_request, queue_request,
           intake_cmd_valid, intake_on,
    input  ready
  );
  modport sink (
    input  valid, top_raw, top_debounced, mid_raw, mid_debounced, bot_raw,
           fire_request, fire_lockout, reverse_request, queue_request,
           intake_cmd_valid, intake_on,
    output ready
  );
endinterface

interface clbs_out_if;
  logic                valid;
  logic                ready;
  logic signed [15:0]  lift_drive;
  logic signed [15:0]  intake_drive;
  logic [1:0]          balls_held;
  logic [2:0]          sensor_code;

  modport source (
    output valid, lift_drive, intake_drive, balls_held, sensor_code,
    input  ready
  );
  modport sink (
    input  valid, lift_drive, intake_drive, balls_held, sensor_code,
    output ready
  );
endinterface

/* rtl/core/conveyor_lift_ball_sequencer_core.sv */
// Lift/intake ball sequencer: one control tick in, one drive result out.
// An accepted tick's result is in the output register in the next cycle.
// Throughput: one tick per cycle while the output register is empty or taken;
// the state update and priority chain settle in one pass of logic ahead of it.
// Reset (async, active low): count 2, ages saturated, drives 0, flags clear,
// configuration at its defaults, output register empty.
module conveyor_lift_ball_sequencer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [clbs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [15:0]                       cfg_data_i,
  clbs_in_if.sink                           in_i,
  clbs_out_if.source                        out_o
);

  // Configuration registers
  clbs_pkg::age_t   hold_q;
  clbs_pkg::level_t lift_speed_q, rev_lift_speed_q, rev_int_speed_q, int_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q           <= clbs_pkg::HoldReset;
      lift_speed_q     <= clbs_pkg::FwdSpeedReset;
      rev_lift_speed_q <= clbs_pkg::RevSpeedReset;
      rev_int_speed_q  <= clbs_pkg::RevSpeedReset;
      int_speed_q      <= clbs_pkg::FwdSpeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clbs_pkg::CfgIntakeHold:   hold_q           <= cfg_data_i;
        clbs_pkg::CfgLiftSpeed:    lift_speed_q     <= cfg_data_i;
        clbs_pkg::CfgRevLiftSpeed: rev_lift_speed_q <= cfg_data_i;
        clbs_pkg::CfgRevIntSpeed:  rev_int_speed_q  <= cfg_data_i;
        clbs_pkg::CfgIntakeSpeed:  int_speed_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  clbs_pkg::count_t ball_count_q, ball_count_d;
  logic             last_top_q, last_top_d;
  logic             last_mid_q, last_mid_d;
  logic             fire_flag_q, fire_flag_d;
  logic             intake_flag_q, intake_flag_d;
  clbs_pkg::age_t   lockout_q, lockout_d;
  clbs_pkg::age_t   fire_age_q, fire_age_d;
  clbs_pkg::age_t   intake_age_q, intake_age_d;
  clbs_pkg::level_t lift_level_q, lift_level_d;
  clbs_pkg::level_t intake_level_q, intake_level_d;
  clbs_pkg::code_t  code_d;

  // Output register
  logic             out_valid_q;
  clbs_pkg::code_t  code_q;

  logic in_fire;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Tick update: pending commands, ages, priority chain, count
  always_comb begin
    logic top_now, top_now_d, mid_rise;
    top_now   = !in_i.top_raw;
    top_now_d = !in_i.top_debounced;
    mid_rise  = in_i.mid_debounced && !last_mid_q;

    fire_flag_d    = fire_flag_q || in_i.fire_request;
    lockout_d      = in_i.fire_request ? in_i.fire_lockout : lockout_q;
    intake_level_d = intake_level_q;
    if (in_i.intake_cmd_valid) begin
      intake_level_d = in_i.intake_on ? int_speed_q : '0;
    end

    fire_age_d    = clbs_pkg::age_inc(fire_age_q);
    intake_age_d  = clbs_pkg::age_inc(intake_age_q);
    intake_flag_d = intake_flag_q;
    if (fire_age_d < lockout_d) begin
      fire_flag_d = 1'b0;
    end
    if (intake_age_d > hold_q) begin
      intake_flag_d = 1'b0;
    end

    lift_level_d = lift_level_q;
    priority if (in_i.reverse_request) begin
      intake_level_d = rev_int_speed_q;
      lift_level_d   = rev_lift_speed_q;
    end else if (top_now && !last_top_q) begin
      // new raw top edge against last debounced presence
      fire_age_d = '0;
    end else if (fire_flag_d) begin
      lift_level_d = lift_speed_q;
    end else if (top_now) begin
      lift_level_d = '0;
    end else if (in_i.queue_request) begin
      lift_level_d = lift_speed_q;
    end else if (in_i.bot_raw) begin
      intake_flag_d = 1'b1;
      intake_age_d  = '0;
      lift_level_d  = lift_speed_q;
    end else if (mid_rise) begin
      intake_flag_d = 1'b0;
      lift_level_d  = '0;
    end else if (intake_flag_d) begin
      lift_level_d = lift_speed_q;
    end else begin
      lift_level_d = '0;
    end

    ball_count_d = ball_count_q;
    if (in_i.reverse_request) begin
      if (!in_i.mid_debounced && last_mid_q && (ball_count_d != '0)) begin
        ball_count_d = ball_count_d - clbs_pkg::count_t'(1);
      end
    end else begin
      if (!top_now_d && last_top_q && (ball_count_d != '0)) begin
        ball_count_d = ball_count_d - clbs_pkg::count_t'(1);
      end
      if (mid_rise && (ball_count_d < clbs_pkg::MaxBalls)) begin
        ball_count_d = ball_count_d + clbs_pkg::count_t'(1);
      end
    end

    last_top_d = top_now_d;
    last_mid_d = in_i.mid_debounced;
    if (!top_now_d) begin
      fire_flag_d = 1'b0;
    end

    code_d = {!in_i.top_raw, !in_i.mid_raw, !in_i.bot_raw};
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_count_q   <= clbs_pkg::ResetBalls;
      last_top_q     <= 1'b0;
      last_mid_q     <= 1'b0;
      fire_flag_q    <= 1'b0;
      intake_flag_q  <= 1'b0;
      lockout_q      <= '0;
      fire_age_q     <= clbs_pkg::AgeMax;
      intake_age_q   <= clbs_pkg::AgeMax;
      lift_level_q   <= '0;
      intake_level_q <= '0;
    end else if (in_fire) begin
      ball_count_q   <= ball_count_d;
      last_top_q     <= last_top_d;
      last_mid_q     <= last_mid_d;
      fire_flag_q    <= fire_flag_d;
      intake_flag_q  <= intake_flag_d;
      lockout_q      <= lockout_d;
      fire_age_q     <= fire_age_d;
      intake_age_q   <= intake_age_d;
      lift_level_q   <= lift_level_d;
      intake_level_q <= intake_level_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sensor code is the only result field not held in state
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      code_q <= code_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lift_drive   = lift_level_q;
  assign out_o.intake_drive = intake_level_q;
  assign out_o.balls_held   = ball_count_q;
  assign out_o.sensor_code  = code_q;

`ifndef SYNTHESIS
  // count holds when no transaction is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(ball_count_q))
    else $error("ball count moved without a transaction");

  // a reverse tick loads the reverse lift level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.reverse_request) |=> (lift_level_q == $past(rev_lift_speed_q)))
    else $error("reverse tick did not load reverse lift level");

  // count moves by at most one per transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ((ball_count_q == $past(ball_count_q))
              || (ball_count_q == $past(ball_count_q) + clbs_pkg::count_t'(1))
              || (ball_count_q == $past(ball_count_q) - clbs_pkg::count_t'(1))))
    else $error("ball count jumped by more than one");
`endif

endmodule
